// ----- src/spq_pkg.sv -----
// Shared types and sizing constants for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY = 256;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SYM_W    = 8;
    localparam int PRI_W    = 32;
    localparam int HELD_W   = 9;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [PRI_W-1:0] pri;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctl_t;

endpackage

// ----- src/sorted_priority_queue.sv -----
// Sorted priority queue top level: cell chain, fill count and result register.
// A bounded queue of up to CAPACITY (symbol, priority) entries kept in ascending
// priority order in a chain of cells; an insert lands ahead of equal priorities and
// a remove returns the head. Every cell compares its key against the incoming
// priority and shifts in the same clock, so a new item is taken every cycle while
// the result register is free or being drained. Each item yields exactly one result
// transfer carrying the removed entry, valid and reject flags, and the entry count
// after the item.
module sorted_priority_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // symbol[7:0], priority_req[39:8]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_symbol[7:0], out_priority[39:8], entries_held[48:40]
    output logic [1:0]  m_tuser    // out_valid[0], rejected[1]
);
    import spq_pkg::*;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_tvalid_reg;
    entry_t            out_entry_reg, out_entry_next;
    logic              out_valid_reg, out_valid_next;
    logic              rejected_reg, rejected_next;

    entry_t            new_entry;
    entry_t            cell_q [CAPACITY];
    logic              cell_go [CAPACITY];
    logic              cell_used [CAPACITY];
    cell_ctl_t         ctl;
    logic              accept;
    logic              is_full, is_empty;

    assign new_entry.sym = s_tdata[7:0];
    assign new_entry.pri = s_tdata[39:8];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign ctl.ins = accept && (s_tuser == KIND_INSERT) && !is_full;
    assign ctl.rem = accept && (s_tuser == KIND_REMOVE) && !is_empty;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            assign cell_used[g] = (CNT_W'(g) < count_reg);

            if (g == 0)
            begin : g_head
                spq_cell u_cell
                (
                    .clk         (clk),
                    .ctl         (ctl),
                    .new_entry   (new_entry),
                    .left_entry  (new_entry),
                    .right_entry (cell_q[(CAPACITY > 1) ? 1 : 0]),
                    .go_left     (1'b0),
                    .used        (cell_used[g]),
                    .entry       (cell_q[g]),
                    .go          (cell_go[g])
                );
            end
            else if (g == CAPACITY - 1)
            begin : g_tail
                spq_cell u_cell
                (
                    .clk         (clk),
                    .ctl         (ctl),
                    .new_entry   (new_entry),
                    .left_entry  (cell_q[g-1]),
                    .right_entry (cell_q[g]),
                    .go_left     (cell_go[g-1]),
                    .used        (cell_used[g]),
                    .entry       (cell_q[g]),
                    .go          (cell_go[g])
                );
            end
            else
            begin : g_mid
                spq_cell u_cell
                (
                    .clk         (clk),
                    .ctl         (ctl),
                    .new_entry   (new_entry),
                    .left_entry  (cell_q[g-1]),
                    .right_entry (cell_q[g+1]),
                    .go_left     (cell_go[g-1]),
                    .used        (cell_used[g]),
                    .entry       (cell_q[g]),
                    .go          (cell_go[g])
                );
            end
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        out_entry_next = out_entry_reg;
        out_valid_next = out_valid_reg;
        rejected_next  = rejected_reg;
        if (accept)
        begin
            out_entry_next = '0;
            out_valid_next = 1'b0;
            rejected_next  = 1'b0;
            case (s_tuser)
                KIND_INSERT:
                begin
                    if (is_full)
                        rejected_next = 1'b1;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                KIND_REMOVE:
                begin
                    if (!is_empty)
                    begin
                        out_entry_next = cell_q[0];
                        out_valid_next = 1'b1;
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    out_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rejected_reg  <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rejected_reg  <= rejected_next;
            if (accept)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_entry_reg <= out_entry_next;
    end

    logic [CNT_W-1:0] held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (accept)
            held_reg <= count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, HELD_W'(held_reg), out_entry_reg.pri, out_entry_reg.sym};
    assign m_tuser  = {rejected_reg, out_valid_reg};

    // Count never runs past the chain length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Head of the chain is never above its neighbor.
    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_q[0].pri <= cell_q[(CAPACITY > 1) ? 1 : 0].pri))
        else $error("chain head out of order");

    // Reject only when the queue was full at accept.
    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == KIND_INSERT) && !is_full) |=> !rejected_reg)
        else $error("insert rejected while space remained");

    // A returned entry always lowers the count by one.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rem |=> (count_reg == $past(count_reg) - CNT_W'(1)) && out_valid_reg)
        else $error("remove did not shrink the queue");

endmodule

// ----- src/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts it left or right.
module spq_cell
(
    input  logic              clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  spq_pkg::entry_t   new_entry,
    input  spq_pkg::entry_t   left_entry,
    input  spq_pkg::entry_t   right_entry,
    input  logic              go_left,
    input  logic              used,
    output spq_pkg::entry_t   entry,
    output logic              go
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Open this slot when it is empty or holds a priority not below the newcomer.
    assign go    = !used || (entry_reg.pri >= new_entry.pri);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins && go)
        begin
            // First open slot takes the newcomer, later ones shift right.
            entry_next = go_left ? left_entry : new_entry;
        end
        else if (ctl.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the sorted priority queue: ordering, empty, full and handshakes.
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [SYM_W-1:0]  sym;
        logic [PRI_W-1:0]  pri;
        logic              valid;
        logic              rejected;
        logic [HELD_W-1:0] held;
    } queue_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // symbol[7:0], priority_req[39:8]
    logic        s_tuser = KIND_INSERT;   // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;   // out_symbol[7:0], out_priority[39:8], entries_held[48:40]
    logic [1:0]  m_tuser;   // out_valid[0], rejected[1]

    entry_t        held_entries[$];     // expected queue contents, lowest priority first
    queue_result_t pending_results[$];  // results owed by the block, oldest first
    int            mismatches = 0;
    bit            idle_on = 1'b1;
    int            rx_stall = 0;

    sorted_priority_queue dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one accepted item to the queue image and record the result it owes.
    task automatic compute_queue_result(input logic kind, input logic [SYM_W-1:0] sym,
                                        input logic [PRI_W-1:0] pri);
        queue_result_t res;
        entry_t        ent;
        int            pos;
        res = '{sym: '0, pri: '0, valid: 1'b0, rejected: 1'b0, held: '0};
        if (kind == KIND_INSERT)
        begin
            if (held_entries.size() >= CAPACITY)
            begin
                res.rejected = 1'b1;
            end
            else
            begin
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].pri < pri)
                    pos++;
                ent.sym = sym;
                ent.pri = pri;
                held_entries.insert(pos, ent);
            end
        end
        else if (held_entries.size() > 0)
        begin
            ent = held_entries.pop_front();
            res.sym   = ent.sym;
            res.pri   = ent.pri;
            res.valid = 1'b1;
        end
        res.held = HELD_W'(held_entries.size());
        pending_results.push_back(res);
    endtask

    task automatic send_item(input logic kind, input logic [SYM_W-1:0] sym,
                             input logic [PRI_W-1:0] pri);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pri, sym};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        compute_queue_result(kind, sym, pri);
    endtask

    function automatic logic [PRI_W-1:0] random_priority();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int count, input int insert_pct);
        logic kind;
        for (int i = 0; i < count; i++)
        begin
            kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
            send_item(kind, SYM_W'($urandom_range(0, 255)), random_priority());
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
            mismatches++;
        end
    endtask

    // Check each result transfer and drive the receiver stalls.
    always @(posedge clk)
    begin
        queue_result_t exp_res;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %h / %b", $time,
                             m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    check_field("out_symbol", 32'(exp_res.sym), 32'(m_tdata[7:0]));
                    check_field("out_priority", exp_res.pri, m_tdata[39:8]);
                    check_field("entries_held", 32'(exp_res.held), 32'(m_tdata[48:40]));
                    check_field("out_valid", 32'(exp_res.valid), 32'(m_tuser[0]));
                    check_field("rejected", 32'(exp_res.rejected), 32'(m_tuser[1]));
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rx_stall = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL sorted_priority_queue");
        $finish;
    end

    task automatic test_empty_remove();
        send_item(KIND_REMOVE, 8'h3C, 32'h1234_5678);
    endtask

    task automatic test_field_extremes();
        send_item(KIND_INSERT, 8'hFF, 32'hFFFF_FFFF);
        send_item(KIND_INSERT, 8'h00, 32'h0000_0000);
        send_item(KIND_INSERT, 8'hA5, 32'h8000_0000);
        send_item(KIND_INSERT, 8'h5A, 32'h7FFF_FFFF);
        repeat (4) send_item(KIND_REMOVE, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // Newcomers go ahead of entries with an equal priority.
    task automatic test_equal_priority();
        send_item(KIND_INSERT, 8'd1, 32'd100);
        send_item(KIND_INSERT, 8'd2, 32'd100);
        send_item(KIND_INSERT, 8'd3, 32'd100);
        send_item(KIND_INSERT, 8'd4, 32'd50);
        send_item(KIND_INSERT, 8'd5, 32'd200);
        repeat (6) send_item(KIND_REMOVE, 8'h00, 32'h0);
    endtask

    task automatic test_random_mix();
        run_random(400, 50);
    endtask

    // Insert-heavy: reach capacity and exercise rejected inserts.
    task automatic test_fill_and_overflow();
        run_random(450, 85);
    endtask

    // Remove-heavy: drain to empty and exercise removes from an empty queue.
    task automatic test_drain_underflow();
        run_random(450, 15);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        run_random(200, 50);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_remove();
        test_field_extremes();
        test_equal_priority();
        test_random_mix();
        test_fill_and_overflow();
        test_drain_underflow();
        test_back_to_back();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS sorted_priority_queue");
        else
            $display("FAIL sorted_priority_queue");
        $finish;
    end

endmodule
